// ===== design/top_k_strongest_tracker_core_macros.svh =====
// assertion macros for the strongest tracker core
`ifndef TOP_K_STRONGEST_TRACKER_CORE_MACROS_SVH
`define TOP_K_STRONGEST_TRACKER_CORE_MACROS_SVH

// implication in the same cycle
`define TKST_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkst check failed");

// implication into the following cycle
`define TKST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkst check failed");

`endif

// ===== design/tkst_pkg.sv =====
`timescale 1ns / 1ps
package tkst_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 8;
   localparam int KEY_W  = 48;
   localparam int RANK_W = 3;

   // one sighting
   typedef struct packed {
      logic [KEY_W-1:0]   ap_key;
      logic signed [7:0]  ap_strength;
      logic [7:0]         ap_channel;
   } req_word_type;

   // one dumped slot
   typedef struct packed {
      logic [RANK_W-1:0]  rank;
      logic               slot_used;
      logic [KEY_W-1:0]   slot_key;
      logic signed [7:0]  slot_strength;
      logic [7:0]         slot_channel;
      logic               last_slot;
   } rsp_word_type;

   // one stored table entry
   typedef struct packed {
      logic               used;
      logic [KEY_W-1:0]   key;
      logic signed [7:0]  strength;
      logic [7:0]         channel;
   } slot_type;

   localparam slot_type SLOT_RESET = '{used: 1'b0, key: '0, strength: -8'sd128, channel: '0};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DUMP
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic dump;
      logic last;
   } dp_cmd_type;

endpackage

// ===== design/tkst_ctrl.sv =====
`timescale 1ns / 1ps
module tkst_ctrl #(
   parameter int TABLE_SLOTS = tkst_pkg::TABLE_SLOTS_DEFAULT,
   parameter int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output tkst_pkg::dp_cmd_type cmd,
   output logic [IDX_W-1:0]     idx
);
   import tkst_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   ctrl_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              at_last;

   assign at_last = (cnt_ff == LAST_IDX);
   assign idx     = cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (at_last) state_in = ST_DUMP;
         end
         ST_DUMP: begin
            if (at_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // slot counter, wraps at the end of each pass
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_SCAN || state_ff == ST_DUMP) begin
         cnt_in = at_last ? '0 : cnt_ff + 1'b1;
      end
   end

   // outputs
   always_comb begin
      busy     = 1'b1;
      cmd      = '0;
      cmd.last = at_last;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN: cmd.scan = 1'b1;
         ST_DUMP: cmd.dump = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/tkst_datapath.sv =====
`timescale 1ns / 1ps
module tkst_datapath #(
   parameter int TABLE_SLOTS = tkst_pkg::TABLE_SLOTS_DEFAULT,
   parameter int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tkst_pkg::dp_cmd_type   cmd,
   input  logic [IDX_W-1:0]       idx,
   input  tkst_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   output tkst_pkg::rsp_word_type rsp_data
);
   import tkst_pkg::*;

   // slot table as a rotating line, slot 0 is the read point
   slot_type          slot_ff [TABLE_SLOTS];
   slot_type          head;
   slot_type          tail_in;
   slot_type          emit;
   slot_type          carry_ff;
   slot_type          fresh;

   req_word_type      req_ff;
   logic              match_found_ff;
   logic [IDX_W-1:0]  match_idx_ff;
   logic              ins_found_ff;
   logic [IDX_W-1:0]  ins_idx_ff;
   logic              hit_key;
   logic              beats;

   logic              rsp_valid_ff;
   rsp_word_type      rsp_data_ff, rsp_data_in;

   assign head    = slot_ff[0];
   assign hit_key = head.used && (head.key == req_ff.ap_key);
   assign beats   = !head.used || (req_ff.ap_strength > head.strength);

   assign fresh = '{used: 1'b1, key: req_ff.ap_key, strength: req_ff.ap_strength,
                    channel: req_ff.ap_channel};

   // entry that belongs at this rank after the update
   always_comb begin
      emit = head;
      if (match_found_ff) begin
         if (idx == match_idx_ff) begin
            emit.strength = req_ff.ap_strength;
            emit.channel  = req_ff.ap_channel;
         end
      end else if (ins_found_ff) begin
         if (idx == ins_idx_ff) emit = fresh;
         else if (idx > ins_idx_ff) emit = carry_ff;
      end
   end

   assign tail_in = cmd.dump ? emit : head;

   // table rotation, one slot per cycle in both passes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TABLE_SLOTS; j++) slot_ff[j] <= SLOT_RESET;
      end else if (cmd.scan || cmd.dump) begin
         for (int j = 0; j < TABLE_SLOTS - 1; j++) slot_ff[j] <= slot_ff[j+1];
         slot_ff[TABLE_SLOTS-1] <= tail_in;
      end
   end

   // captured sighting and previous head for the shift-down
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.dump) carry_ff <= head;
   end

   // search results
   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         ins_found_ff   <= 1'b0;
         match_idx_ff   <= '0;
         ins_idx_ff     <= '0;
      end else if (cmd.load) begin
         match_found_ff <= 1'b0;
         ins_found_ff   <= 1'b0;
      end else if (cmd.scan) begin
         if (!match_found_ff && hit_key) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= idx;
         end
         if (!ins_found_ff && beats) begin
            ins_found_ff <= 1'b1;
            ins_idx_ff   <= idx;
         end
      end
   end

   // result word
   always_comb begin
      rsp_data_in.rank          = RANK_W'(idx);
      rsp_data_in.slot_used     = emit.used;
      rsp_data_in.slot_key      = emit.key;
      rsp_data_in.slot_strength = emit.strength;
      rsp_data_in.slot_channel  = emit.channel;
      rsp_data_in.last_slot     = cmd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.dump;
      if (cmd.dump) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/top_k_strongest_tracker_core.sv =====
`timescale 1ns / 1ps
// each accepted sighting starts a search pass over the rotating slot table,
// then a dump pass that emits one registered result word per slot, rank 0 first;
// busy stays high through both passes, so a new sighting is accepted only once
// the dump pass is through and the controller is back in idle
// results are strobed for one cycle each; the receiver cannot stall
// reset is synchronous and active high; it empties every slot and returns to idle
module top_k_strongest_tracker_core #(
   parameter int TABLE_SLOTS = tkst_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tkst_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   output tkst_pkg::rsp_word_type rsp_data
);
   import tkst_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   dp_cmd_type        cmd;
   logic [IDX_W-1:0]  idx;

   tkst_ctrl #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_W(IDX_W)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .idx   (idx)
   );

   tkst_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_W(IDX_W)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .idx       (idx),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`include "top_k_strongest_tracker_core_macros.svh"

   // an accepted word always starts a search pass
   `TKST_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // results only come out of a dump pass
   `TKST_ASSERT_SAME(a_rsp_in_pass, clock, reset, rsp_valid, $past(busy))
   // the dump ends after the final slot
   `TKST_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_data.last_slot, !rsp_valid)
   // ranks follow on back to back within a dump
   `TKST_ASSERT_NEXT(a_rank_step, clock, reset, rsp_valid && !rsp_data.last_slot, rsp_valid && (rsp_data.rank == $past(rsp_data.rank) + 3'd1))

endmodule

// ===== test/top_k_strongest_tracker_core_test.sv =====
`timescale 1ns / 1ps
module top_k_strongest_tracker_core_test;
   import tkst_pkg::*;

   localparam int NUM_SLOTS   = TABLE_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 18;
   localparam int RANDOM_ITEMS = 102;
   localparam int POOL_SIZE   = 12;

   // one sighting row: the word to send and, if pinned, the expected top-of-table word
   typedef struct {
      req_word_type word;
      bit           pinned;
      rsp_word_type top;
   } sighting_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_data;
   logic         rsp_valid;
   rsp_word_type rsp_data;

   // model copy of the ranked table
   slot_type         model_slot[NUM_SLOTS];
   rsp_word_type     dump_words_q[$];
   sighting_row_type top_pin_q[$];
   sighting_row_type directed_rows[$];
   sighting_row_type pin_word;
   int               dump_pos;
   int               fail_count;
   int               cycle_count;

   top_k_strongest_tracker_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // apply one sighting to the model table and queue the dump it causes
   task automatic predict_dump(input req_word_type s);
      int           hit;
      int           pos;
      rsp_word_type w;
      hit = -1;
      pos = -1;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (hit < 0 && model_slot[i].used && model_slot[i].key == s.ap_key)
            hit = i;
      if (hit >= 0) begin
         // known station: overwrite in place, no re-sort
         model_slot[hit].strength = s.ap_strength;
         model_slot[hit].channel  = s.ap_channel;
      end else begin
         // first slot that is empty or strictly weaker
         for (int i = 0; i < NUM_SLOTS; i++)
            if (pos < 0 && (!model_slot[i].used || s.ap_strength > model_slot[i].strength))
               pos = i;
         if (pos >= 0) begin
            for (int j = NUM_SLOTS - 1; j > pos; j--)
               model_slot[j] = model_slot[j-1];
            model_slot[pos].used     = 1'b1;
            model_slot[pos].key      = s.ap_key;
            model_slot[pos].strength = s.ap_strength;
            model_slot[pos].channel  = s.ap_channel;
         end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         w.rank          = RANK_W'(i);
         w.slot_used     = model_slot[i].used;
         w.slot_key      = model_slot[i].key;
         w.slot_strength = model_slot[i].strength;
         w.slot_channel  = model_slot[i].channel;
         w.last_slot     = (i == NUM_SLOTS - 1);
         dump_words_q.push_back(w);
      end
   endtask

   // field by field comparison of one dumped word
   task automatic compare_word(input rsp_word_type exp, input rsp_word_type got,
                               input string what);
      if (exp.rank !== got.rank) begin
         fail_count++;
         $display("%0t %s rank: expected %0d actual %0d", $time, what, exp.rank, got.rank);
      end
      if (exp.slot_used !== got.slot_used) begin
         fail_count++;
         $display("%0t %s slot_used: expected %b actual %b", $time, what,
                  exp.slot_used, got.slot_used);
      end
      if (exp.slot_key !== got.slot_key) begin
         fail_count++;
         $display("%0t %s slot_key: expected %h actual %h", $time, what,
                  exp.slot_key, got.slot_key);
      end
      if (exp.slot_strength !== got.slot_strength) begin
         fail_count++;
         $display("%0t %s slot_strength: expected %0d actual %0d", $time, what,
                  exp.slot_strength, got.slot_strength);
      end
      if (exp.slot_channel !== got.slot_channel) begin
         fail_count++;
         $display("%0t %s slot_channel: expected %h actual %h", $time, what,
                  exp.slot_channel, got.slot_channel);
      end
      if (exp.last_slot !== got.last_slot) begin
         fail_count++;
         $display("%0t %s last_slot: expected %b actual %b", $time, what,
                  exp.last_slot, got.last_slot);
      end
   endtask

   // result checking, then prediction on an accepted sighting
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (dump_pos == 0 && top_pin_q.size() > 0) begin
               pin_word = top_pin_q.pop_front();
               if (pin_word.pinned)
                  compare_word(pin_word.top, rsp_data, "top slot");
            end
            if (dump_words_q.size() == 0) begin
               fail_count++;
               $display("%0t unexpected word: expected none actual %h", $time, rsp_data);
            end else begin
               compare_word(dump_words_q.pop_front(), rsp_data, "dump");
            end
            dump_pos = (dump_pos + 1) % NUM_SLOTS;
         end
         if (start && !busy)
            predict_dump(req_data);
      end
   end

   // queue a directed row; pinned rows expect the sighting itself at rank 0
   task automatic add_row(input logic [KEY_W-1:0] key, input int strength,
                          input logic [7:0] channel, input bit pinned);
      sighting_row_type row;
      row.word.ap_key      = key;
      row.word.ap_strength = 8'(strength);
      row.word.ap_channel  = channel;
      row.pinned           = pinned;
      row.top.rank          = '0;
      row.top.slot_used     = 1'b1;
      row.top.slot_key      = key;
      row.top.slot_strength = 8'(strength);
      row.top.slot_channel  = channel;
      row.top.last_slot     = 1'b0;
      directed_rows.push_back(row);
   endtask

   // present one word and hold it until taken
   task automatic send_sighting(input sighting_row_type row, input bit may_idle);
      int gap;
      top_pin_q.push_back(row);
      if (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         gap = $urandom_range(1, 20);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= row.word;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every queued word has come back
   task automatic drain_dumps();
      start <= 1'b0;
      @(posedge clock);
      while (dump_words_q.size() > 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [KEY_W-1:0] key_pool[POOL_SIZE];
      logic [63:0]      wide;
      sighting_row_type row;
      int               n;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      dump_pos  = 0;
      fail_count = 0;
      for (int i = 0; i < NUM_SLOTS; i++) model_slot[i] = SLOT_RESET;

      // extremes, in-place update, strict ordering, full table, lost entry
      add_row(48'h0000_0000_0001,  -60, 8'h06, 1'b1);
      add_row(48'hFFFF_FFFF_FFFF,    0, 8'hFF, 1'b1);
      add_row(48'h0000_0000_0000, -128, 8'h00, 1'b0);
      add_row(48'hFFFF_FFFF_FFFF, -128, 8'h01, 1'b1);
      add_row(48'hA5A5_A5A5_A5A5,  127, 8'h5A, 1'b1);
      add_row(48'h5A5A_5A5A_5A5A,    1, 8'hA5, 1'b0);
      add_row(48'h1234_5678_9ABC,   -1, 8'h01, 1'b0);
      add_row(48'h0F0F_0F0F_0F0F,  -64, 8'h02, 1'b0);
      add_row(48'hF0F0_F0F0_F0F0,  -64, 8'h03, 1'b0);
      add_row(48'h00FF_00FF_00FF, -100, 8'h04, 1'b0);
      add_row(48'hDEAD_BEEF_CAFE, -128, 8'h09, 1'b0);
      add_row(48'h0000_0000_0000,  -20, 8'h0B, 1'b0);
      add_row(48'h8000_0000_0000, -128, 8'h80, 1'b0);
      add_row(48'hA5A5_A5A5_A5A5, -128, 8'h07, 1'b1);
      add_row(48'h7FFF_FFFF_FFFE,  127, 8'hC3, 1'b1);
      add_row(48'h0F0F_0F0F_0F0F, -128, 8'h3C, 1'b0);
      add_row(48'h0000_0000_0001,  -80, 8'h7F, 1'b0);
      add_row(48'h5555_AAAA_5555, -127, 8'hAA, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sighting(directed_rows[i], 1'b1);
      drain_dumps();

      // random part: a small pool of stations so that updates are frequent
      for (int i = 0; i < POOL_SIZE; i++) begin
         wide = {$urandom, $urandom};
         key_pool[i] = wide[KEY_W-1:0];
      end
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if ($urandom_range(0, 99) < 5) begin
            wide = {$urandom, $urandom};
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = wide[KEY_W-1:0];
         end
         wide = {$urandom, $urandom};
         if ($urandom_range(0, 99) < 85)
            row.word.ap_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            row.word.ap_key = wide[KEY_W-1:0];
         if ($urandom_range(0, 99) < 80) begin
            n = $urandom_range(0, 128);
            row.word.ap_strength = 8'(-n);
         end else begin
            row.word.ap_strength = 8'($urandom_range(0, 255));
         end
         row.word.ap_channel = 8'($urandom_range(0, 255));
         row.pinned = 1'b0;
         row.top    = '0;
         if (k == 60)
            drain_dumps();
         // long stretch with no idling
         send_sighting(row, !(k >= 40 && k < 80));
      end

      start <= 1'b0;
      while (dump_words_q.size() > 0) @(posedge clock);
      repeat (2 * NUM_SLOTS + 4) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
